>>> rtl/assert_macros.svh
// Assertion macros shared by the RTL; empty when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// condition holds at every edge out of reset
`define A_ALWAYS(lbl, clk, rstn, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (expr)) else $error("assertion failed");
// antecedent implies consequent in the same cycle
`define A_IMPLY(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error("assertion failed");
`else
`define A_ALWAYS(lbl, clk, rstn, expr)
`define A_IMPLY(lbl, clk, rstn, ante, cons)
`endif
`endif

>>> rtl/pqe_pkg.sv
// Shared types and constants of the motor and quadrature encoder model.
package pqe_pkg;

    // field widths
    localparam int THRESH_BITS = 8;
    localparam int SLOPE_BITS  = 16;
    localparam int ICPT_BITS   = 16;
    localparam int NUM_BITS    = 24;
    localparam int SPEED_BITS  = 16;
    localparam int DUTY_BITS   = 8;
    localparam int REQ_BITS    = 2;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 24;

    // period numerator is scaled by 16 before the divide
    localparam int NUM_SHIFT   = 4;
    localparam int DVD_BITS    = NUM_BITS + NUM_SHIFT;
    localparam int QCNT_BITS   = $clog2(DVD_BITS + 1);

    // mult-add result: 24-bit product plus intercept scaled by 256, signed
    localparam int SUM_BITS    = 26;
    localparam int SPD_FRAC    = 8;

    // stream payload widths
    localparam int S_TDATA_W   = 16;
    localparam int S_TUSER_W   = REQ_BITS;
    localparam int M_TDATA_W   = 24;

    localparam int PERIOD_BITS_DEF = 20;

    // register reset values
    localparam logic [THRESH_BITS-1:0] THRESH_RST = 8'd35;
    localparam logic [SLOPE_BITS-1:0]  SLOPE_RST  = 16'd11305;
    localparam logic [ICPT_BITS-1:0]   ICPT_RST   = 16'hFBCD; // -1075
    localparam logic [NUM_BITS-1:0]    NUM_RST    = 24'd4000000;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_THRESH = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOPE  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ICPT   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_NUM    = 3'd3;

    // request kinds
    typedef enum logic [REQ_BITS-1:0] {
        REQ_DUTY = 2'd0,
        REQ_DIR  = 2'd1,
        REQ_TICK = 2'd2
    } t_req;

    // divider status toward the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

>>> rtl/pwm_speed_quadrature_encoder_model.sv
// Top level: motor speed and quadrature encoder model with bit-serial period divider.
//
//  channel   | dir | handshake               | payload
//  ----------+-----+-------------------------+------------------------------------
//  s_axis    | in  | tvalid/tready           | tuser req_type, tdata duty/dir
//  m_axis    | out | tvalid/tready           | tdata phases, step, dir, rpm
//  cfg       | in  | i_cfg_we (no wait)      | i_cfg_idx, i_cfg_data
//
//  Direction writes and ticks complete directly; one word per clock while m_axis is ready
//  and no divide is running. A duty write that yields a running speed waits for the
//  bit-serial period divider; other duty writes complete directly.
//  The result sits in an output register; a new word is taken when it drains that edge.
//  Synchronous active-low reset; no clearing pass.
`include "assert_macros.svh"

module pwm_speed_quadrature_encoder_model import pqe_pkg::*; #(
    parameter int PERIOD_BITS = PERIOD_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // slave stream
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [S_TDATA_W-1:0]  s_axis_tdata,  // [7:0] pwm_duty, [8] dir_level
    input  logic [S_TUSER_W-1:0]  s_axis_tuser,  // [1:0] req_type
    // master stream
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [M_TDATA_W-1:0]  m_axis_tdata,  // [0] phase_a, [1] phase_b, [2] step_event,
                                                 // [3] step_clockwise, [19:4] rpm_value
    // configuration
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int SAT_W = (DVD_BITS > PERIOD_BITS) ? DVD_BITS : PERIOD_BITS;
    localparam logic [SAT_W-1:0] PMAX = SAT_W'({PERIOD_BITS{1'b1}});

    typedef enum logic {
        S_IDLE,
        S_DIV
    } t_state;

    // configuration registers
    logic [THRESH_BITS-1:0] r_thresh;
    logic [SLOPE_BITS-1:0]  r_slope;
    logic [ICPT_BITS-1:0]   r_icpt;
    logic [NUM_BITS-1:0]    r_num;

    // model state
    t_state                 r_state,   n_state;
    logic [PERIOD_BITS-1:0] r_desired, n_desired;
    logic [PERIOD_BITS-1:0] r_running, n_running;
    logic [PERIOD_BITS-1:0] r_left,    n_left;
    logic                   r_armed,   n_armed;
    logic [1:0]             r_phase,   n_phase;
    logic                   r_cw,      n_cw;
    logic [SPEED_BITS-1:0]  r_speed,   n_speed;
    logic                   r_step,    n_step;
    logic                   r_ovalid,  n_ovalid;

    logic                   w_accept;
    t_req                   w_req;
    logic [DUTY_BITS-1:0]   w_duty;
    logic [23:0]            w_prod;
    logic signed [SUM_BITS-1:0] w_sum;
    logic                   w_stop;
    logic [SUM_BITS-SPD_FRAC-1:0] w_q;
    logic [SPEED_BITS-1:0]  w_speed;
    logic                   w_div_start;
    t_div_stat              w_div_stat;
    logic [DVD_BITS-1:0]    w_quot;
    logic [SAT_W-1:0]       w_qext;
    logic [PERIOD_BITS-1:0] w_pdes;

    assign s_axis_tready = (r_state == S_IDLE) && (!r_ovalid || m_axis_tready);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_req         = t_req'(s_axis_tuser);
    assign w_duty        = s_axis_tdata[DUTY_BITS-1:0];

    // speed: slope * duty + intercept * 256 in Q.8; speed is its saturated integer part
    assign w_prod  = 24'(r_slope) * 24'(w_duty);
    assign w_sum   = $signed({2'b00, w_prod})
                   + $signed({{2{r_icpt[ICPT_BITS-1]}}, r_icpt, 8'h00});
    assign w_stop  = w_sum < $signed(SUM_BITS'(256));
    assign w_q     = w_sum[SUM_BITS-1:SPD_FRAC];
    assign w_speed = (|w_q[SUM_BITS-SPD_FRAC-1:SPEED_BITS]) ? '1 : w_q[SPEED_BITS-1:0];

    // period divider, started on a duty write with positive speed
    pqe_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend ({r_num, NUM_SHIFT'(0)}),
        .i_divisor  (w_speed),
        .o_stat     (w_div_stat),
        .o_quot     (w_quot)
    );

    // saturate quotient to the period range
    assign w_qext = SAT_W'(w_quot);
    assign w_pdes = (w_qext > PMAX) ? PERIOD_BITS'(PMAX) : PERIOD_BITS'(w_qext);

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thresh <= THRESH_RST;
            r_slope  <= SLOPE_RST;
            r_icpt   <= ICPT_RST;
            r_num    <= NUM_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_THRESH: r_thresh <= i_cfg_data[THRESH_BITS-1:0];
                CFG_SLOPE:  r_slope  <= i_cfg_data[SLOPE_BITS-1:0];
                CFG_ICPT:   r_icpt   <= i_cfg_data[ICPT_BITS-1:0];
                CFG_NUM:    r_num    <= i_cfg_data[NUM_BITS-1:0];
                default: ;
            endcase
        end
    end

    // sequencer and model update
    always_comb begin
        n_state     = r_state;
        n_desired   = r_desired;
        n_running   = r_running;
        n_left      = r_left;
        n_armed     = r_armed;
        n_phase     = r_phase;
        n_cw        = r_cw;
        n_speed     = r_speed;
        n_step      = r_step;
        n_ovalid    = r_ovalid && !m_axis_tready;
        w_div_start = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_ovalid = 1'b1;
                    n_step   = 1'b0;
                    unique case (w_req)
                        REQ_DUTY: begin
                            if (w_duty < r_thresh) begin
                                n_desired = '0;
                            end else if (w_stop) begin
                                n_speed   = '0;
                                n_desired = '0;
                            end else begin
                                // result waits for the divider
                                n_speed     = w_speed;
                                n_ovalid    = 1'b0;
                                w_div_start = 1'b1;
                                n_state     = S_DIV;
                            end
                        end
                        REQ_DIR: begin
                            n_cw = s_axis_tdata[DUTY_BITS];
                        end
                        REQ_TICK: begin
                            if (r_armed) begin
                                if (r_left > PERIOD_BITS'(1)) begin
                                    n_left = r_left - 1'b1;
                                end else begin
                                    // expiry: step if a period was running, reload
                                    if (r_running != '0) begin
                                        n_phase = r_phase + (r_cw ? 2'd1 : 2'd3);
                                        n_step  = 1'b1;
                                    end
                                    n_running = r_desired;
                                    n_left    = r_desired;
                                    n_armed   = (r_desired != '0);
                                end
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_DIV: begin
                if (w_div_stat.done) begin
                    n_desired = w_pdes;
                    if (r_running == '0 && w_pdes != '0) begin
                        n_armed = 1'b1;
                        n_left  = w_pdes;
                    end
                    n_ovalid = 1'b1;
                    n_step   = 1'b0;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_desired <= '0;
            r_running <= '0;
            r_left    <= '0;
            r_armed   <= 1'b0;
            r_phase   <= 2'd0;
            r_cw      <= 1'b1;
            r_speed   <= '0;
            r_step    <= 1'b0;
            r_ovalid  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_desired <= n_desired;
            r_running <= n_running;
            r_left    <= n_left;
            r_armed   <= n_armed;
            r_phase   <= n_phase;
            r_cw      <= n_cw;
            r_speed   <= n_speed;
            r_step    <= n_step;
            r_ovalid  <= n_ovalid;
        end
    end

    // output word straight from state; state only moves when no word is held or the word drains
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {4'h0, r_speed, r_cw, r_step, r_phase[1], r_phase[0]};

    // checks
    `A_IMPLY(a_div_busy_stall, i_clk, i_rst_n, w_div_stat.busy, !s_axis_tready)
    `A_IMPLY(a_div_done_state, i_clk, i_rst_n, w_div_stat.done, r_state == S_DIV)
    `A_IMPLY(a_disarmed_zero, i_clk, i_rst_n, !r_armed, r_left == '0)
    `A_IMPLY(a_running_armed, i_clk, i_rst_n, r_running != '0, r_armed)

endmodule

>>> rtl/pqe_div.sv
// Restoring divider, one quotient bit per cycle, for the step period.
module pqe_div import pqe_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [DVD_BITS-1:0]   i_dividend,
    input  logic [SPEED_BITS-1:0] i_divisor,
    output t_div_stat             o_stat,
    output logic [DVD_BITS-1:0]   o_quot
);

    logic                  r_busy;
    logic                  r_done;
    logic [QCNT_BITS-1:0]  r_cnt;
    logic [SPEED_BITS-1:0] r_rem;
    logic [DVD_BITS-1:0]   r_quo;
    logic [SPEED_BITS-1:0] r_dsr;

    logic [SPEED_BITS:0]   w_shift;
    logic [SPEED_BITS:0]   w_diff;
    logic                  w_ge;

    // one trial subtraction per cycle; remainder stays below the divisor
    assign w_shift = {r_rem, r_quo[DVD_BITS-1]};
    assign w_ge    = w_shift >= {1'b0, r_dsr};
    assign w_diff  = w_shift - {1'b0, r_dsr};

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= QCNT_BITS'(DVD_BITS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == QCNT_BITS'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath: dividend shifts out as quotient shifts in
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dsr <= i_divisor;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[SPEED_BITS-1:0] : w_shift[SPEED_BITS-1:0];
            r_quo <= {r_quo[DVD_BITS-2:0], w_ge};
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quot      = r_quo;

endmodule
